@@ rtl/soc_pkg.sv @@
// shared types and constants for the sphere to oriented box contact block
package soc_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned AXIS_BITS  = 16;
  localparam int unsigned AXIS_FRAC  = 14;
  localparam int unsigned VEC_BITS   = 3 * COORD_BITS;
  localparam int unsigned AXV_BITS   = 3 * AXIS_BITS;
  localparam int          NST        = 18;

  typedef struct packed {
    logic [VEC_BITS-1:0]   ball_center;
    logic [COORD_BITS-1:0] ball_radius;
    logic [VEC_BITS-1:0]   box_center;
    logic [VEC_BITS-1:0]   box_size;
    logic [AXV_BITS-1:0]   box_axis_x;
    logic [AXV_BITS-1:0]   box_axis_y;
    logic [AXV_BITS-1:0]   box_axis_z;
    logic [15:0]           ball_friction;
    logic [15:0]           box_friction;
  } soc_in_t;

  typedef struct packed {
    logic                         hit;
    logic [VEC_BITS-1:0]          contact_point;
    logic [VEC_BITS-1:0]          box_arm;
    logic [VEC_BITS-1:0]          ball_arm;
    logic [AXV_BITS-1:0]          contact_normal;
    logic signed [COORD_BITS-1:0] penetration;
    logic [15:0]                  mean_friction;
    logic                         center_inside;
  } soc_out_t;

endpackage

@@ rtl/soc_sqrt_step.sv @@
// four iterations of the digit-by-digit integer square root
module soc_sqrt_step (
  input  logic [31:0] x_i,
  input  logic [31:0] res_i,
  input  logic [3:0]  first_i,
  output logic [31:0] x_o,
  output logic [31:0] res_o
);
  import soc_pkg::*;

  logic [32:0] x, rs, b;
  int s;

  always_comb begin
    x = {1'b0, x_i};
    rs = {1'b0, res_i};
    b = '0;
    s = 0;
    for (int t = 0; t < 4; t++) begin
      s = 30 - 2 * (int'(first_i) + t);
      b = 33'd1 << s;
      if (x >= rs + b) begin
        x = x - (rs + b);
        rs = (rs >> 1) + b;
      end else begin
        rs = rs >> 1;
      end
    end
    x_o = x[31:0];
    res_o = rs[31:0];
  end

endmodule

@@ rtl/soc_div_step.sv @@
// up to four quotient bits of a restoring divider lane
module soc_div_step (
  input  logic [17:0] rem_i,
  input  logic [14:0] q_i,
  input  logic [17:0] den_i,
  input  logic [14:0] nlo_i,
  input  logic [3:0]  hi_i,
  input  logic [2:0]  cnt_i,
  output logic [17:0] rem_o,
  output logic [14:0] q_o
);
  import soc_pkg::*;

  logic [18:0] t19;
  logic [17:0] rem;
  logic [14:0] q;
  int idx;

  always_comb begin
    rem = rem_i;
    q = q_i;
    t19 = '0;
    idx = 0;
    for (int t = 0; t < 4; t++) begin
      if (t < int'(cnt_i)) begin
        idx = int'(hi_i) - t;
        t19 = {rem, nlo_i[idx[3:0]]};
        if (t19 >= {1'b0, den_i}) begin
          t19 = t19 - {1'b0, den_i};
          q = {q[13:0], 1'b1};
        end else begin
          q = {q[13:0], 1'b0};
        end
        rem = t19[17:0];
      end
    end
    rem_o = rem;
    q_o = q;
  end

endmodule

@@ rtl/sphere_obb_contact.sv @@
// top level: sphere against oriented box contact pipeline
// throughput: one word per cycle while out_ready_i does not stall the pipeline, set by the fully pipelined datapath
// square root: 4 stages of 4 iterations, normal divide: 4 stages per lane
// each stage holds its word while the next is full and cannot advance, bubbles are squeezed out
// reset clears all stage valid bits, no other state
module sphere_obb_contact (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  soc_pkg::soc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output soc_pkg::soc_out_t out_data_o
);
  import soc_pkg::*;

  typedef struct packed {
    logic [2:0][16:0]       d;
    logic [2:0][2:0][15:0]  ax;
    logic [2:0][28:0]       ext;
    logic [15:0]            r;
    logic [2:0][15:0]       bc;
    logic [15:0]            mf;
    logic [2:0][2:0][32:0]  prod;
    logic [2:0][16:0]       cproj;
    logic                   clamped;
    logic [2:0][18:0]       o;
    logic [2:0][19:0]       m;
    logic [2:0]             neg;
    logic [2:0][31:0]       sq;
    logic [31:0]            r2;
    logic                   big;
    logic                   hit;
    logic [31:0]            acc;
    logic [31:0]            sres;
    logic [16:0]            len;
    logic [17:0]            den;
    logic [2:0][17:0]       rem;
    logic [2:0][14:0]       qt;
    logic [2:0][15:0]       n;
    logic [2:0][33:0]       sp;
    soc_out_t               res;
  } pipe_t;

  function automatic logic signed [39:0] rnd14(input logic signed [39:0] x);
    logic [39:0] mag, rr;
    mag = x[39] ? 40'(-x) : 40'(x);
    rr = (mag + 40'd8192) >> AXIS_FRAC;
    return x[39] ? -$signed(rr) : $signed(rr);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [39:0] x);
    if (x > 40'sd32767) return 16'h7fff;
    else if (x < -40'sd32768) return 16'h8000;
    else return x[15:0];
  endfunction

  pipe_t pq [NST];
  pipe_t pd [NST];
  logic [NST-1:0] vq;
  logic [NST-1:0] en;

  logic [3:0][31:0] sx_o, sr_o;
  logic [3:0][2:0][17:0] dr_o;
  logic [3:0][2:0][14:0] dq_o;

  always_comb begin
    en[NST-1] = !vq[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) en[k] = !vq[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vq[NST-1];
  assign out_data_o  = pq[NST-1].res;

  for (genvar g = 0; g < 4; g++) begin : g_sqrt
    soc_sqrt_step u_sqrt (
      .x_i    (pq[6+g].acc),
      .res_i  (pq[6+g].sres),
      .first_i(4'(4 * g)),
      .x_o    (sx_o[g]),
      .res_o  (sr_o[g])
    );
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      soc_div_step u_div (
        .rem_i(pq[11+g].rem[j]),
        .q_i  (pq[11+g].qt[j]),
        .den_i(pq[11+g].den),
        .nlo_i(pq[11+g].len[14:0]),
        .hi_i (4'(14 - 4 * g)),
        .cnt_i((g == 3) ? 3'd3 : 3'd4),
        .rem_o(dr_o[g][j]),
        .q_o  (dq_o[g][j])
      );
    end
  end

  logic signed [39:0] acc40, ext40, tmp40;
  logic signed [19:0] v20;
  logic [33:0] sum34;
  logic [16:0] fsum;

  always_comb begin
    acc40 = '0;
    ext40 = '0;
    tmp40 = '0;
    v20 = '0;
    sum34 = '0;
    fsum = '0;

    // input decode
    pd[0] = '0;
    for (int j = 0; j < 3; j++) begin
      pd[0].d[j] = 17'($signed(in_data_i.ball_center[16*j +: 16]))
                 - 17'($signed(in_data_i.box_center[16*j +: 16]));
      pd[0].ax[0][j] = in_data_i.box_axis_x[16*j +: 16];
      pd[0].ax[1][j] = in_data_i.box_axis_y[16*j +: 16];
      pd[0].ax[2][j] = in_data_i.box_axis_z[16*j +: 16];
      pd[0].ext[j] = {in_data_i.box_size[16*j +: 16], 13'd0};
      pd[0].bc[j] = in_data_i.box_center[16*j +: 16];
    end
    pd[0].r = in_data_i.ball_radius;
    fsum = {1'b0, in_data_i.ball_friction} + {1'b0, in_data_i.box_friction} + 17'd1;
    pd[0].mf = fsum[16:1];

    // projection products
    pd[1] = pq[0];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        pd[1].prod[i][j] = 33'($signed(pq[0].d[j]) * $signed(pq[0].ax[i][j]));

    // clamp to half extents
    pd[2] = pq[1];
    pd[2].clamped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc40 = 40'($signed(pq[1].prod[i][0])) + 40'($signed(pq[1].prod[i][1]))
            + 40'($signed(pq[1].prod[i][2]));
      ext40 = $signed(40'(pq[1].ext[i]));
      if (acc40 > ext40) begin
        acc40 = ext40;
        pd[2].clamped = 1'b1;
      end
      if (acc40 < -ext40) begin
        acc40 = -ext40;
        pd[2].clamped = 1'b1;
      end
      tmp40 = rnd14(acc40);
      pd[2].cproj[i] = tmp40[16:0];
    end

    // back to world products
    pd[3] = pq[2];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        pd[3].prod[i][j] = 33'($signed(pq[2].cproj[i]) * $signed(pq[2].ax[i][j]));

    // closest point offset and separation
    pd[4] = pq[3];
    for (int j = 0; j < 3; j++) begin
      acc40 = 40'($signed(pq[3].prod[0][j])) + 40'($signed(pq[3].prod[1][j]))
            + 40'($signed(pq[3].prod[2][j]));
      tmp40 = pq[3].clamped ? rnd14(acc40) : 40'($signed(pq[3].d[j]));
      pd[4].o[j] = tmp40[18:0];
      v20 = 20'($signed(pq[3].d[j])) - 20'($signed(tmp40[18:0]));
      pd[4].neg[j] = v20[19];
      pd[4].m[j] = v20[19] ? 20'(-v20) : 20'(v20);
    end

    // squares
    pd[5] = pq[4];
    pd[5].big = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (pq[4].m[j] > {4'd0, pq[4].r}) pd[5].big = 1'b1;
      pd[5].sq[j] = pq[4].m[j][15:0] * pq[4].m[j][15:0];
    end
    pd[5].r2 = pq[4].r * pq[4].r;

    // hit test
    pd[6] = pq[5];
    sum34 = {2'd0, pq[5].sq[0]} + {2'd0, pq[5].sq[1]} + {2'd0, pq[5].sq[2]};
    pd[6].hit = !pq[5].big && (sum34 <= {2'd0, pq[5].r2});
    pd[6].acc = sum34[31:0];
    pd[6].sres = '0;

    // square root
    for (int g = 0; g < 4; g++) begin
      pd[7+g] = pq[6+g];
      pd[7+g].acc = sx_o[g];
      pd[7+g].sres = sr_o[g];
    end

    // rounded length and divider setup
    pd[11] = pq[10];
    pd[11].len = 17'(pq[10].sres) + ((pq[10].acc > pq[10].sres) ? 17'd1 : 17'd0);
    pd[11].den = {pd[11].len, 1'b0};
    for (int j = 0; j < 3; j++) begin
      pd[11].rem[j] = pq[10].m[j][17:0] + {16'd0, pd[11].len[16:15]};
      pd[11].qt[j] = '0;
    end

    // normal divide
    for (int g = 0; g < 4; g++) begin
      pd[12+g] = pq[11+g];
      pd[12+g].rem = dr_o[g];
      pd[12+g].qt = dq_o[g];
    end

    // signed normal and ball arm product
    pd[16] = pq[15];
    for (int j = 0; j < 3; j++) begin
      if (pq[15].len == '0) pd[16].n[j] = '0;
      else if (pq[15].neg[j]) pd[16].n[j] = -{1'b0, pq[15].qt[j]};
      else pd[16].n[j] = {1'b0, pq[15].qt[j]};
      pd[16].sp[j] = 34'(-(17'($signed(pd[16].n[j])) * $signed({1'b0, pq[15].r})));
    end

    // result word
    pd[17] = pq[16];
    pd[17].res = '0;
    if (pq[16].hit) begin
      pd[17].res.hit = 1'b1;
      for (int j = 0; j < 3; j++) begin
        pd[17].res.contact_point[16*j +: 16] =
          sat16(40'($signed(pq[16].bc[j])) + 40'($signed(pq[16].o[j])));
        pd[17].res.box_arm[16*j +: 16] = sat16(40'($signed(pq[16].o[j])));
        pd[17].res.contact_normal[16*j +: 16] = pq[16].n[j];
        pd[17].res.ball_arm[16*j +: 16] = (pq[16].len == '0) ? 16'd0 :
          sat16(rnd14(40'($signed(pq[16].sp[j]))));
      end
      pd[17].res.penetration = sat16(40'(pq[16].len) - 40'(pq[16].r));
      pd[17].res.mean_friction = pq[16].mf;
      pd[17].res.center_inside = (pq[16].len == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq <= '0;
    end else begin
      if (en[0]) vq[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vq[k] <= vq[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) pq[k] <= pd[k];
    end
  end

endmodule
